// ===== hdl/glyph_curve_band_binner_top_assert.svh =====
// ---------------------------------------------------------------------------
// glyph curve band binner assertion macros
// shared property wrappers for the port checker
// ---------------------------------------------------------------------------
`ifndef GLYPH_CURVE_BAND_BINNER_TOP_ASSERT_SVH
`define GLYPH_CURVE_BAND_BINNER_TOP_ASSERT_SVH

// same-cycle implication, off during reset
`define GCBB_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define GCBB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/gcbb_pkg.sv =====
// ---------------------------------------------------------------------------
// gcbb_pkg
// types, codes and constants of the glyph curve band binner
// ---------------------------------------------------------------------------
package gcbb_pkg;

  localparam int COORD_FRAC_BITS = 16;
  localparam int COORD_W         = COORD_FRAC_BITS + 1;
  localparam int ADDR_W          = 14;
  localparam int BAND_CNT_W      = 5;
  localparam int BYTE_W          = 8;
  localparam int KIND_W          = 3;
  localparam int CFG_IDX_W       = 3;
  localparam int MAX_CURVES_DEF  = 64;
  localparam int MAX_BANDS_DEF   = 16;
  localparam int QUANT_SCALE     = 255;
  localparam int BYTE_MAX        = 255;
  localparam int LOW_BITS        = 7;
  localparam logic [LOW_BITS-1:0] LOW_MASK = 7'h7F;
  localparam logic [BAND_CNT_W-1:0] BANDS_RESET = 5'd8;

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_DRAIN = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_CURVE    = 3'd0,
    KIND_ROW_DIM  = 3'd1,
    KIND_ROW_CELL = 3'd2,
    KIND_COL_DIM  = 3'd3,
    KIND_COL_CELL = 3'd4,
    KIND_NONE     = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    PH_ROW_DIM  = 3'd0,
    PH_ROW_CELL = 3'd1,
    PH_COL_DIM  = 3'd2,
    PH_COL_CELL = 3'd3,
    PH_DONE     = 3'd4
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COL_BANDS    = 3'd0,
    REG_ROW_BANDS    = 3'd1,
    REG_CURVE_BASE   = 3'd2,
    REG_ROW_DIM_BASE = 3'd3,
    REG_ROW_CELL_BASE = 3'd4,
    REG_COL_DIM_BASE = 3'd5,
    REG_COL_CELL_BASE = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0]         action;
    logic               bin_it;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] ctrl_x;
    logic [COORD_W-1:0] ctrl_y;
    logic [COORD_W-1:0] box_min_x;
    logic [COORD_W-1:0] box_max_x;
    logic [COORD_W-1:0] box_min_y;
    logic [COORD_W-1:0] box_max_y;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] word_kind;
    logic [ADDR_W-1:0] word_address;
    logic [BYTE_W-1:0] byte_a;
    logic [BYTE_W-1:0] byte_b;
    logic [BYTE_W-1:0] byte_c;
    logic [BYTE_W-1:0] byte_d;
    logic              last_word;
    logic              dropped;
  } out_item_t;

  typedef struct packed {
    logic [BAND_CNT_W-1:0] col_band_count;
    logic [BAND_CNT_W-1:0] row_band_count;
    logic [ADDR_W-1:0]     curve_base;
    logic [ADDR_W-1:0]     row_dim_base;
    logic [ADDR_W-1:0]     row_cell_base;
    logic [ADDR_W-1:0]     col_dim_base;
    logic [ADDR_W-1:0]     col_cell_base;
  } cfg_t;

  // round(v * 255) in byte range, saturating
  function automatic logic [BYTE_W-1:0] quant(input logic [COORD_W-1:0] raw);
    logic [COORD_W+BYTE_W:0] sum;
    logic [COORD_W+BYTE_W-COORD_FRAC_BITS:0] q;
    sum = (COORD_W+BYTE_W+1)'(raw) * (COORD_W+BYTE_W+1)'(QUANT_SCALE)
        + (COORD_W+BYTE_W+1)'(1 << (COORD_FRAC_BITS - 1));
    q = sum[COORD_W+BYTE_W:COORD_FRAC_BITS];
    return (q > BYTE_MAX) ? BYTE_W'(BYTE_MAX) : q[BYTE_W-1:0];
  endfunction

endpackage

// ===== hdl/gcbb_cfg.sv =====
// ---------------------------------------------------------------------------
// gcbb_cfg
// configuration register file
// ---------------------------------------------------------------------------
module gcbb_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [gcbb_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [gcbb_pkg::ADDR_W-1:0]     wr_data,
  output gcbb_pkg::cfg_t                  cfg
);
  import gcbb_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.col_band_count <= BANDS_RESET;
      cfg.row_band_count <= BANDS_RESET;
      cfg.curve_base     <= '0;
      cfg.row_dim_base   <= '0;
      cfg.row_cell_base  <= '0;
      cfg.col_dim_base   <= '0;
      cfg.col_cell_base  <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_COL_BANDS:     cfg.col_band_count <= wr_data[BAND_CNT_W-1:0];
        REG_ROW_BANDS:     cfg.row_band_count <= wr_data[BAND_CNT_W-1:0];
        REG_CURVE_BASE:    cfg.curve_base     <= wr_data;
        REG_ROW_DIM_BASE:  cfg.row_dim_base   <= wr_data;
        REG_ROW_CELL_BASE: cfg.row_cell_base  <= wr_data;
        REG_COL_DIM_BASE:  cfg.col_dim_base   <= wr_data;
        REG_COL_CELL_BASE: cfg.col_cell_base  <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/gcbb_core.sv =====
// ---------------------------------------------------------------------------
// gcbb_core
// band store, drain sequencer and result datapath
// ---------------------------------------------------------------------------
module gcbb_core #(
  parameter int MAX_CURVES = gcbb_pkg::MAX_CURVES_DEF,
  parameter int MAX_BANDS  = gcbb_pkg::MAX_BANDS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  gcbb_pkg::cfg_t      cfg,
  input  logic                step,
  input  gcbb_pkg::in_item_t  item,
  output gcbb_pkg::out_item_t result
);
  import gcbb_pkg::*;

  localparam int CIW = $clog2(MAX_CURVES);
  localparam int CCW = $clog2(MAX_CURVES + 1);
  localparam int BIW = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
  localparam int BNW = $clog2(MAX_BANDS + 1);
  localparam int PW  = COORD_W + BNW;

  typedef struct packed {
    phase_t         ph;
    logic [BNW-1:0] band;
    logic [CIW-1:0] bit_idx;
  } pos_t;

  // store
  logic [MAX_CURVES-1:0] row_map [MAX_BANDS];
  logic [MAX_CURVES-1:0] col_map [MAX_BANDS];
  logic [CCW-1:0]        row_cnt [MAX_BANDS];
  logic [CCW-1:0]        col_cnt [MAX_BANDS];
  logic [CCW-1:0]        curve_total;
  phase_t                drain_phase, drain_phase_next;
  logic [BIW-1:0]        drain_band, drain_band_next;
  logic [CIW-1:0]        drain_bit, drain_bit_next;
  logic [ADDR_W-1:0]     row_cell_tally, row_cell_tally_next;
  logic [ADDR_W-1:0]     col_cell_tally, col_cell_tally_next;

  logic [BNW-1:0] eff_row, eff_col;
  logic           full;
  logic [CIW-1:0] new_idx;
  logic [MAX_BANDS-1:0] row_hit, col_hit;

  pos_t              pos_start, pos_mid, pos_end;
  logic              row_sel, dim_ph, cell_ph, bit_hit, emitted;
  logic [BIW-1:0]    band_idx;
  logic [MAX_CURVES-1:0] cur_map, above;
  logic [CCW-1:0]    cur_cnt;
  logic [ADDR_W-1:0] cur_tally, cur_cbase, cur_dbase, cell_start, cell_index;
  logic [CIW:0]      first_bit, later_bit;

  function automatic logic [BNW-1:0] eff_bands(input logic [BAND_CNT_W-1:0] r);
    if (r == '0) return BNW'(1);
    if (r > MAX_BANDS) return BNW'(MAX_BANDS);
    return BNW'(r);
  endfunction

  // lowest set bit, found flag on top
  function automatic logic [CIW:0] lowest_set(input logic [MAX_CURVES-1:0] v);
    logic [CIW:0] r;
    r = '0;
    for (int i = MAX_CURVES - 1; i >= 0; i--) begin
      if (v[i]) r = {1'b1, CIW'(i)};
    end
    return r;
  endfunction

  function automatic pos_t normalize(input pos_t p, input logic [BNW-1:0] er,
                                     input logic [BNW-1:0] ec);
    pos_t r;
    r = p;
    if (r.ph == PH_ROW_DIM && r.band >= er) r = '{PH_COL_DIM, '0, '0};
    if (r.ph == PH_COL_DIM && r.band >= ec) r = '{PH_DONE, '0, '0};
    if (r.band >= MAX_BANDS) r = '{PH_DONE, '0, '0};
    return r;
  endfunction

  // band range of one box axis
  function automatic logic [MAX_BANDS-1:0] band_range(input logic [COORD_W-1:0] lo_raw,
      input logic [COORD_W-1:0] hi_raw, input logic [BNW-1:0] n);
    logic [PW-1:0] lo_p;
    logic [PW:0]   hi_p;
    logic [PW-COORD_FRAC_BITS-1:0] lo;
    logic [PW-COORD_FRAC_BITS:0]   hi;
    logic [MAX_BANDS-1:0] r;
    lo_p = PW'(lo_raw) * PW'(n);
    hi_p = (PW+1)'(hi_raw) * (PW+1)'(n) + (PW+1)'((1 << COORD_FRAC_BITS) - 1);
    lo = lo_p[PW-1:COORD_FRAC_BITS];
    hi = hi_p[PW:COORD_FRAC_BITS];
    if (hi > n) hi = (PW-COORD_FRAC_BITS+1)'(n);
    for (int b = 0; b < MAX_BANDS; b++) begin
      r[b] = (b >= lo) && (b < hi);
    end
    return r;
  endfunction

  assign eff_row = eff_bands(cfg.row_band_count);
  assign eff_col = eff_bands(cfg.col_band_count);
  assign full    = curve_total >= MAX_CURVES;
  assign new_idx = curve_total[CIW-1:0];
  assign col_hit = band_range(item.box_min_x, item.box_max_x, eff_col);
  assign row_hit = band_range(item.box_min_y, item.box_max_y, eff_row);

  // drain position and band selection
  assign pos_start  = normalize('{drain_phase, BNW'(drain_band), drain_bit}, eff_row, eff_col);
  assign row_sel    = (pos_start.ph == PH_ROW_DIM) || (pos_start.ph == PH_ROW_CELL);
  assign dim_ph     = (pos_start.ph == PH_ROW_DIM) || (pos_start.ph == PH_COL_DIM);
  assign cell_ph    = (pos_start.ph == PH_ROW_CELL) || (pos_start.ph == PH_COL_CELL);
  assign band_idx   = pos_start.band[BIW-1:0];
  assign cur_map    = row_sel ? row_map[band_idx] : col_map[band_idx];
  assign cur_cnt    = row_sel ? row_cnt[band_idx] : col_cnt[band_idx];
  assign cur_tally  = row_sel ? row_cell_tally : col_cell_tally;
  assign cur_cbase  = row_sel ? cfg.row_cell_base : cfg.col_cell_base;
  assign cur_dbase  = row_sel ? cfg.row_dim_base : cfg.col_dim_base;
  assign cell_start = cur_cbase + cur_tally;
  assign cell_index = cfg.curve_base + ADDR_W'(pos_start.bit_idx);
  assign bit_hit    = cur_map[pos_start.bit_idx];

  always_comb begin
    for (int i = 0; i < MAX_CURVES; i++) begin
      above[i] = i > pos_start.bit_idx;
    end
  end

  assign first_bit = lowest_set(cur_map);
  assign later_bit = lowest_set(cur_map & above);

  // drain next state
  always_comb begin
    pos_mid             = pos_start;
    row_cell_tally_next = row_cell_tally;
    col_cell_tally_next = col_cell_tally;
    case (pos_start.ph)
      PH_ROW_DIM, PH_COL_DIM: begin
        if (cur_cnt != '0) begin
          pos_mid.ph      = (pos_start.ph == PH_ROW_DIM) ? PH_ROW_CELL : PH_COL_CELL;
          pos_mid.bit_idx = first_bit[CIW-1:0];
        end else begin
          pos_mid.band = pos_start.band + 1'b1;
        end
      end
      PH_ROW_CELL, PH_COL_CELL: begin
        if (bit_hit) begin
          if (row_sel) row_cell_tally_next = row_cell_tally + 1'b1;
          else         col_cell_tally_next = col_cell_tally + 1'b1;
        end
        if (later_bit[CIW]) begin
          pos_mid.bit_idx = later_bit[CIW-1:0];
        end else begin
          pos_mid.band    = pos_start.band + 1'b1;
          pos_mid.ph      = row_sel ? PH_ROW_DIM : PH_COL_DIM;
          pos_mid.bit_idx = '0;
        end
      end
      default: ;
    endcase
    pos_end          = normalize(pos_mid, eff_row, eff_col);
    drain_phase_next = pos_end.ph;
    drain_band_next  = pos_end.band[BIW-1:0];
    drain_bit_next   = pos_end.bit_idx;
  end

  assign emitted = dim_ph || (cell_ph && bit_hit);

  // result word
  always_comb begin
    result = '0;
    result.word_kind = KIND_NONE;
    case (action_t'(item.action))
      ACT_ADD: begin
        if (full) begin
          result.dropped = 1'b1;
        end else begin
          result.word_kind    = KIND_CURVE;
          result.word_address = cfg.curve_base + ADDR_W'(new_idx);
          result.byte_a       = quant(item.start_x);
          result.byte_b       = quant(item.start_y);
          result.byte_c       = quant(item.ctrl_x);
          result.byte_d       = quant(item.ctrl_y);
        end
      end
      ACT_DRAIN: begin
        if (dim_ph) begin
          result.word_kind    = row_sel ? KIND_ROW_DIM : KIND_COL_DIM;
          result.word_address = cur_dbase + ADDR_W'(pos_start.band);
          result.byte_a       = BYTE_W'(cell_start >> LOW_BITS);
          result.byte_b       = BYTE_W'(cell_start[LOW_BITS-1:0] & LOW_MASK);
          result.byte_c       = BYTE_W'(cur_cnt >> LOW_BITS);
          result.byte_d       = BYTE_W'(LOW_BITS'(cur_cnt) & LOW_MASK);
        end else if (cell_ph && bit_hit) begin
          result.word_kind    = row_sel ? KIND_ROW_CELL : KIND_COL_CELL;
          result.word_address = cell_start;
          result.byte_a       = BYTE_W'(cell_index >> LOW_BITS);
          result.byte_b       = BYTE_W'(cell_index[LOW_BITS-1:0] & LOW_MASK);
        end
        result.last_word = emitted && (pos_end.ph == PH_DONE);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      curve_total    <= '0;
      drain_phase    <= PH_ROW_DIM;
      drain_band     <= '0;
      drain_bit      <= '0;
      row_cell_tally <= '0;
      col_cell_tally <= '0;
      for (int b = 0; b < MAX_BANDS; b++) begin
        row_map[b] <= '0;
        col_map[b] <= '0;
        row_cnt[b] <= '0;
        col_cnt[b] <= '0;
      end
    end else if (step) begin
      case (action_t'(item.action))
        ACT_ADD: begin
          if (!full) begin
            curve_total <= curve_total + 1'b1;
            if (item.bin_it) begin
              for (int b = 0; b < MAX_BANDS; b++) begin
                if (row_hit[b]) begin
                  row_map[b][new_idx] <= 1'b1;
                  row_cnt[b]          <= row_cnt[b] + 1'b1;
                end
                if (col_hit[b]) begin
                  col_map[b][new_idx] <= 1'b1;
                  col_cnt[b]          <= col_cnt[b] + 1'b1;
                end
              end
            end
          end
        end
        ACT_DRAIN: begin
          drain_phase    <= drain_phase_next;
          drain_band     <= drain_band_next;
          drain_bit      <= drain_bit_next;
          row_cell_tally <= row_cell_tally_next;
          col_cell_tally <= col_cell_tally_next;
        end
        ACT_CLEAR: begin
          curve_total    <= '0;
          drain_phase    <= PH_ROW_DIM;
          drain_band     <= '0;
          drain_bit      <= '0;
          row_cell_tally <= '0;
          col_cell_tally <= '0;
          for (int b = 0; b < MAX_BANDS; b++) begin
            row_map[b] <= '0;
            col_map[b] <= '0;
            row_cnt[b] <= '0;
            col_cnt[b] <= '0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/glyph_curve_band_binner_top.sv =====
// ---------------------------------------------------------------------------
// glyph_curve_band_binner_top
// bins quadratic glyph curves into row and column bands and drains the tables
// ---------------------------------------------------------------------------
// channel   direction  handshake               payload
// in        input      in_valid / in_ready     in_data   (gcbb_pkg::in_item_t)
// out       output     out_valid / out_ready   out_data  (gcbb_pkg::out_item_t)
// cfg       input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// one item per cycle sustained while the result is not stalled; each item gives exactly one result item
// an item passes the input register, then the result register
// the band store updates when an item leaves the input register
// synchronous active-high reset clears store, drain position and the valid flags of both registers
// a stalled result holds the input register; the input side stalls only when
// both registers are full
// ---------------------------------------------------------------------------
module glyph_curve_band_binner_top #(
  parameter int MAX_CURVES = gcbb_pkg::MAX_CURVES_DEF,
  parameter int MAX_BANDS  = gcbb_pkg::MAX_BANDS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  gcbb_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output gcbb_pkg::out_item_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gcbb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gcbb_pkg::ADDR_W-1:0]    cfg_data
);
  import gcbb_pkg::*;

  cfg_t      cfg;
  in_item_t  held;
  logic      held_valid;
  logic      advance;
  out_item_t result;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  // input register moves on whenever the result register is free
  assign advance  = held_valid && (!out_valid || out_ready);
  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held <= in_data;
    end
  end

  gcbb_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  gcbb_core #(
    .MAX_CURVES (MAX_CURVES),
    .MAX_BANDS  (MAX_BANDS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .step   (advance),
    .item   (held),
    .result (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

endmodule

// ===== hdl/gcbb_checker.sv =====
// ---------------------------------------------------------------------------
// gcbb_checker
// port-level checks on the result channel
// ---------------------------------------------------------------------------
`include "glyph_curve_band_binner_top_assert.svh"

module gcbb_checker (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input gcbb_pkg::out_item_t out_data
);
  import gcbb_pkg::*;

  `GCBB_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")
  `GCBB_ASSERT_IMPLY(a_none_zero, clk, rst, out_valid && out_data.word_kind == KIND_NONE, out_data.word_address == '0 && out_data.byte_a == '0 && out_data.byte_b == '0 && out_data.byte_c == '0 && out_data.byte_d == '0, "empty result carries data")
  `GCBB_ASSERT_IMPLY(a_drop_none, clk, rst, out_valid && out_data.dropped, out_data.word_kind == KIND_NONE && !out_data.last_word, "dropped curve with a word")
  `GCBB_ASSERT_IMPLY(a_last_kind, clk, rst, out_valid && out_data.last_word, out_data.word_kind == KIND_ROW_DIM || out_data.word_kind == KIND_ROW_CELL || out_data.word_kind == KIND_COL_DIM || out_data.word_kind == KIND_COL_CELL, "last flag on a non-table word")

endmodule

bind glyph_curve_band_binner_top gcbb_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
